// ===== rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// shared constants, types and character decode for the infix to postfix
// converter
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam logic [2:0] K_OTHER = 3'd0;
  localparam logic [2:0] K_OPND  = 3'd1;
  localparam logic [2:0] K_LPAR  = 3'd2;
  localparam logic [2:0] K_RPAR  = 3'd3;
  localparam logic [2:0] K_OPER  = 3'd4;
  localparam logic [2:0] K_END   = 3'd5;

  typedef struct packed {
    logic latch;
    logic push;
    logic push_live;
    logic pop;
    logic emit_in;
    logic emit_top;
    logic emit_term;
    logic last;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic [2:0] kind;
    logic       cnt_zero;
    logic       cnt_one;
    logic       top_lpar;
    logic       top_ge;
    logic       below_ge;
    logic       below_lpar;
  } sts_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS:       p = 2'd1;
      CH_MUL, CH_DIV, CH_MOD:  p = 2'd2;
      CH_POW:                  p = 2'd3;
      default:                 p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] c, input logic e);
    logic [2:0] k;
    if (e) begin
      k = K_END;
    end else if (is_operand(c)) begin
      k = K_OPND;
    end else if (c == CH_LPAR) begin
      k = K_LPAR;
    end else if (c == CH_RPAR) begin
      k = K_RPAR;
    end else if (prec_of(c) != 2'd0) begin
      k = K_OPER;
    end else begin
      k = K_OTHER;
    end
    return k;
  endfunction

endpackage

// ===== rtl/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// sequencer: accepts characters, walks pops for operators, close parens and the
// end-of-expression flush
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  itp_pkg::sts_t sts,
  output itp_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_OPER  = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !sts.slot_free;
        if (in_valid && sts.slot_free) begin
          cmd.latch = 1'b1;
          unique case (sts.kind)
            itp_pkg::K_OPND: begin
              cmd.emit_in = 1'b1;
              cmd.last    = 1'b1;
            end
            itp_pkg::K_LPAR: begin
              cmd.push      = 1'b1;
              cmd.push_live = 1'b1;
            end
            itp_pkg::K_RPAR: state_next = ST_CLOSE;
            itp_pkg::K_OPER: state_next = ST_OPER;
            itp_pkg::K_END:  state_next = ST_FLUSH;
            default: ;
          endcase
        end
      end
      ST_OPER: begin
        if (!sts.cnt_zero && sts.top_ge) begin
          if (sts.slot_free) begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
            cmd.last     = sts.cnt_one || !sts.below_ge;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (sts.cnt_zero) begin
          state_next = ST_IDLE;
        end else if (sts.top_lpar) begin
          cmd.pop    = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
          cmd.last     = sts.cnt_one || sts.below_lpar;
        end
      end
      ST_FLUSH: begin
        if (sts.slot_free) begin
          if (sts.cnt_zero) begin
            cmd.emit_term = 1'b1;
            cmd.last      = 1'b1;
            cmd.clear     = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.pop      = 1'b1;
            cmd.emit_top = !sts.top_lpar;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/itp_dp.sv =====
// ----------------------------------------------------------------------------
// itp_dp
// datapath: operator stack with top and below registers, count, sticky
// overflow flag and the output word register
// ----------------------------------------------------------------------------
module itp_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_char,
  input  logic          end_of_expr,
  input  itp_pkg::cmd_t cmd,
  output itp_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          terminator,
  output logic          overflow,
  output logic          last_result
);

  logic [7:0]               stack [itp_pkg::STACK_DEPTH];
  logic [7:0]               top_reg;
  logic [7:0]               below;
  logic [7:0]               cur_char;
  logic [itp_pkg::CNT_W-1:0] count;
  logic                     overflow_seen;
  logic [1:0]               cur_prec;

  logic [itp_pkg::CNT_W-1:0] cnt_m1;
  logic [itp_pkg::CNT_W-1:0] cnt_m3;
  logic [7:0]               push_data;
  logic                     full;
  logic                     load;

  assign cnt_m1    = count - itp_pkg::CNT_W'(1);
  assign cnt_m3    = count - itp_pkg::CNT_W'(3);
  assign push_data = cmd.push_live ? in_char : cur_char;
  assign full      = (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign load      = cmd.emit_in || cmd.emit_top || cmd.emit_term;

  assign sts.slot_free  = !out_valid || !out_stall;
  assign sts.kind       = itp_pkg::classify(in_char, end_of_expr);
  assign sts.cnt_zero   = (count == '0);
  assign sts.cnt_one    = (count == itp_pkg::CNT_W'(1));
  assign sts.top_lpar   = (top_reg == itp_pkg::CH_LPAR);
  assign sts.top_ge     = (itp_pkg::prec_of(top_reg) >= cur_prec);
  assign sts.below_ge   = (itp_pkg::prec_of(below) >= cur_prec);
  assign sts.below_lpar = (below == itp_pkg::CH_LPAR);

  // below holds the entry under the top, refilled by a registered read on pop
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_char <= in_char;
      cur_prec <= itp_pkg::prec_of(in_char);
    end
    if (cmd.push && !full) begin
      if (count != '0) begin
        stack[cnt_m1[itp_pkg::IDX_W-1:0]] <= top_reg;
        below                             <= top_reg;
      end
      top_reg <= push_data;
    end else if (cmd.pop) begin
      top_reg <= below;
      below   <= stack[cnt_m3[itp_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.push) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        count <= count + itp_pkg::CNT_W'(1);
      end
    end else if (cmd.pop) begin
      count <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= cmd.emit_term ? 8'h00 : (cmd.emit_in ? in_char : top_reg);
      terminator  <= cmd.emit_term;
      overflow    <= overflow_seen;
      last_result <= cmd.last;
    end
  end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an infix character stream to postfix words
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_char, end_of_expr
//   out      output     out_valid/out_stall out_char, terminator, overflow,
//                                           last_result
//
// operands and ignored characters are taken in the idle state, '(' is pushed
// there; an operator goes through OPER, popping each operator of equal or
// higher precedence before its push; ')' goes through CLOSE, popping
// operators up to and including the matching '('. end of expression goes
// through FLUSH, popping every stacked entry, then emits the terminator.
// a stalled output holds the sequencer until its word is taken.
// synchronous reset empties the stack and clears the overflow flag.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_expr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       terminator,
  output logic       overflow,
  output logic       last_result
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_char     (in_char),
    .end_of_expr (end_of_expr),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .terminator  (terminator),
    .overflow    (overflow),
    .last_result (last_result)
  );

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_in || cmd.emit_top || cmd.emit_term) |-> sts.slot_free)
    else $error("word loaded while output slot busy");

  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop in the same cycle");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> sts.cnt_zero)
    else $error("stack not empty after flush");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && terminator) |-> (last_result && (out_char == 8'h00)))
    else $error("terminator word malformed");

endmodule

// ===== tb/infix_to_postfix_converter_test.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// self-checking bench for the infix to postfix converter: a short table of
// hand-picked characters, then random expressions (well-formed, deeply nested
// and malformed). Every accepted character runs through a software copy of the
// operator stack, and each output word is compared against the oldest
// expectation. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_test;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
    logic       ovf;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       typed;
    logic       has_word;
    word_t      word;
  } row_t;

  localparam int    N_DIRECTED   = 23;
  localparam int    N_RANDOM     = 207;
  localparam int    HOLD_CYCLES  = 150;
  localparam int    WATCHDOG     = 2000;
  localparam word_t NO_WORD      = '0;

  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{"0",               1'b0, 1'b1, 1'b1, '{"0", 1'b0, 1'b0, 1'b1}},
    '{8'h00,             1'b0, 1'b1, 1'b0, NO_WORD},
    '{8'hFF,             1'b0, 1'b1, 1'b0, NO_WORD},
    '{8'hFF,             1'b1, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{itp_pkg::CH_LPAR,  1'b0, 1'b0, 1'b0, NO_WORD},
    '{"A",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_PLUS,  1'b0, 1'b0, 1'b0, NO_WORD},
    '{"z",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_MUL,   1'b0, 1'b0, 1'b0, NO_WORD},
    '{"9",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_POW,   1'b0, 1'b0, 1'b0, NO_WORD},
    '{"Z",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, NO_WORD},
    '{"a",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_DIV,   1'b0, 1'b0, 1'b0, NO_WORD},
    '{"b",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_MOD,   1'b0, 1'b0, 1'b0, NO_WORD},
    '{"c",               1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_RPAR,  1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_RPAR,  1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_LPAR,  1'b0, 1'b0, 1'b0, NO_WORD},
    '{itp_pkg::CH_MUL,   1'b0, 1'b0, 1'b0, NO_WORD},
    '{"a",               1'b1, 1'b0, 1'b0, NO_WORD}
  };

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_char     = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_char;
  logic       terminator;
  logic       overflow;
  logic       last_result;

  row_t       stimulus[$];
  word_t      postfix_expected[$];
  word_t      step_words[$];
  logic [7:0] op_pile [itp_pkg::STACK_DEPTH];
  int         pile_fill;
  logic       ovf_seen;
  word_t      want;
  int         errors      = 0;
  int         idle_cycles = 0;
  bit         calm        = 1'b0;
  bit         held        = 1'b0;
  bit         hold_go     = 1'b0;

  infix_to_postfix_converter dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .end_of_expr (end_of_expr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .terminator  (terminator),
    .overflow    (overflow),
    .last_result (last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int op_rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:                 return 1;
      itp_pkg::CH_MUL, itp_pkg::CH_DIV, itp_pkg::CH_MOD:   return 2;
      itp_pkg::CH_POW:                                     return 3;
      default:                                             return 0;
    endcase
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic emit_word(input logic [7:0] c, input logic t);
    step_words.push_back('{c, t, ovf_seen, 1'b0});
  endtask

  task automatic push_op(input logic [7:0] c);
    if (pile_fill < itp_pkg::STACK_DEPTH) begin
      op_pile[pile_fill] = c;
      pile_fill++;
    end else begin
      ovf_seen = 1'b1;
    end
  endtask

  // shunting-yard step: fills step_words with the words one character causes
  task automatic convert_char(input logic [7:0] c, input logic eoe);
    int k;
    step_words.delete();
    if (eoe) begin
      while (pile_fill > 0) begin
        pile_fill--;
        if (op_pile[pile_fill] != itp_pkg::CH_LPAR) emit_word(op_pile[pile_fill], 1'b0);
      end
      emit_word(8'h00, 1'b1);
      ovf_seen = 1'b0;
    end else if (is_alnum(c)) begin
      emit_word(c, 1'b0);
    end else if (c == itp_pkg::CH_LPAR) begin
      push_op(c);
    end else if (c == itp_pkg::CH_RPAR) begin
      while (pile_fill > 0 && op_pile[pile_fill-1] != itp_pkg::CH_LPAR) begin
        emit_word(op_pile[pile_fill-1], 1'b0);
        pile_fill--;
      end
      if (pile_fill > 0) pile_fill--;
    end else if (op_rank(c) > 0) begin
      while (pile_fill > 0 && op_rank(op_pile[pile_fill-1]) >= op_rank(c)) begin
        emit_word(op_pile[pile_fill-1], 1'b0);
        pile_fill--;
      end
      push_op(c);
      // a dropped push flags the pops that came before it
      for (k = 0; k < step_words.size(); k++) step_words[k].ovf = ovf_seen;
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 5))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_MUL;
      3:       return itp_pkg::CH_DIV;
      4:       return itp_pkg::CH_MOD;
      default: return itp_pkg::CH_POW;
    endcase
  endfunction

  task automatic put(input logic [7:0] c, input logic eoe);
    stimulus.push_back('{c, eoe, 1'b0, 1'b0, NO_WORD});
  endtask

  // enough nested parens to run the stack past full
  task automatic add_deep_nesting();
    int levels;
    levels = $urandom_range(itp_pkg::STACK_DEPTH + 1, itp_pkg::STACK_DEPTH + 8);
    repeat (levels) begin
      if ($urandom_range(0, 1) == 1) begin
        put(rand_operand(), 1'b0);
        put(rand_operator(), 1'b0);
      end
      put(itp_pkg::CH_LPAR, 1'b0);
    end
    put(rand_operand(), 1'b0);
    put(rand_operator(), 1'b0);
    put(rand_operand(), 1'b0);
    repeat ($urandom_range(0, levels)) put(itp_pkg::CH_RPAR, 1'b0);
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_expression();
    int terms;
    int open;
    int t;
    if ($urandom_range(0, 7) == 0) begin
      // malformed or noise
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       put(8'($urandom_range(0, 255)), 1'b0);
          1:       put(rand_operator(), 1'b0);
          2:       put($urandom_range(0, 1) ? itp_pkg::CH_LPAR : itp_pkg::CH_RPAR, 1'b0);
          default: put(rand_operand(), 1'b0);
        endcase
      end
    end else begin
      terms = $urandom_range(1, 6);
      open = 0;
      for (t = 0; t < terms; t++) begin
        if ($urandom_range(0, 3) == 0) begin
          put(itp_pkg::CH_LPAR, 1'b0);
          open++;
        end
        put(rand_operand(), 1'b0);
        if ($urandom_range(0, 19) == 0) put(8'($urandom_range(0, 255)), 1'b0);
        if (open > 0 && $urandom_range(0, 2) == 0) begin
          put(itp_pkg::CH_RPAR, 1'b0);
          open--;
        end
        if (t < terms - 1) put(rand_operator(), 1'b0);
      end
      if ($urandom_range(0, 5) != 0) repeat (open) put(itp_pkg::CH_RPAR, 1'b0);
    end
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    forever begin
      @(negedge clk);
      if (!held && hold_go) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (postfix_expected.size() == 0) begin
        $error("unexpected word: out_char %h terminator %b", out_char, terminator);
        errors++;
      end else begin
        want = postfix_expected.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, out_char);
          errors++;
        end
        if (terminator !== want.term) begin
          $error("terminator expected %b actual %b", want.term, terminator);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow expected %b actual %b", want.ovf, overflow);
          errors++;
        end
        if (last_result !== want.last) begin
          $error("last_result expected %b actual %b", want.last, last_result);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int  i;
    int  k;
    bit  pause;
    bit  gap;
    row_t r;
    pile_fill = 0;
    ovf_seen = 1'b0;
    for (k = 0; k < N_DIRECTED; k++) stimulus.push_back(DIRECTED[k]);
    add_deep_nesting();
    while (stimulus.size() < N_DIRECTED + N_RANDOM) begin
      if ($urandom_range(0, 29) == 0) add_deep_nesting();
      else add_expression();
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < stimulus.size(); i++) begin
      r = stimulus[i];
      if (i == N_DIRECTED + 10) hold_go = 1'b1;
      calm = (i >= stimulus.size() - 40);
      pause = (i == N_DIRECTED) || (i == stimulus.size() / 2);
      gap = !calm && $urandom_range(0, 5) == 0;
      if (pause || gap) begin
        in_valid <= 1'b0;
        if (pause) begin
          do @(negedge clk); while (postfix_expected.size() != 0);
        end else begin
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
      end
      in_valid    <= 1'b1;
      in_char     <= r.ch;
      end_of_expr <= r.eoe;
      do @(posedge clk); while (in_stall);
      convert_char(r.ch, r.eoe);
      if (r.typed) begin
        if (r.has_word) postfix_expected.push_back(r.word);
      end else begin
        for (k = 0; k < step_words.size(); k++) postfix_expected.push_back(step_words[k]);
      end
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (postfix_expected.size() != 0) @(posedge clk);
    repeat (2 * itp_pkg::STACK_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
